/* rtl/eoc_pkg.sv */
// Shared types and constants of the effect order checker.
// Used by every module of the block; depends on nothing else.
package eoc_pkg;

   localparam int MAX_STAGES = 32;
   localparam int IDX_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int COUNT_W    = 6;
   localparam int GEN_W      = 64;
   localparam int ID_W       = 32;
   localparam int MASK_W     = 32;
   localparam int KIND_W     = 3;

   localparam logic [KIND_W-1:0] KIND_FORWARD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TRANSPOSE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EDGE_GRAD = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UPDATE    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PUBLISH   = 3'd4;

   typedef enum logic [2:0] {
      VERDICT_OK    = 3'd0,
      VERDICT_ARG   = 3'd1,
      VERDICT_DUP   = 3'd2,
      VERDICT_STALE = 3'd3,
      VERDICT_STATE = 3'd4,
      VERDICT_KIND  = 3'd5
   } verdict_type;

   // One stored stage: its identity and its transitive ancestor mask.
   typedef struct packed {
      logic [ID_W-1:0]   identity;
      logic [MASK_W-1:0] ancestors;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } scan_status_type;

endpackage

/* rtl/effect_order_checker.sv */
// Effect order checker, top level: handshake, generation tracking and verdict.
// Uses eoc_pkg, eoc_stage_mem and eoc_scan.
//
// One request word carries one stage of a sequence; one response word comes
// back for every request word. The response carries the sticky verdict so
// far and the index of the stage where the first error arose; rsp_tlast
// marks the word that closes the sequence, whose verdict is final.
// A stage passes through the prepare, check, scan, evaluate and finish states
// from acceptance to a loaded response; scan and evaluation are skipped when
// the stage fails its argument checks or follows an error. The scan unit reads
// the stage memory once per earlier stage through its single read port. One
// stage is in work at a time; req_tready rises as the previous result is loaded
// into the response register, even while that word is still stalled by the
// receiver, so a new stage is taken only once the previous one is loaded. A
// stalled response holds its word and keeps the next stage waiting once it is done.
// Reset returns the block to the start of a sequence; the stage memory
// needs no clearing, since only entries written earlier in the same
// sequence are ever read.
module effect_order_checker
   import eoc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // stage_count[5:0], start_gen[69:6], stage_identity[101:70],
   // depends_mask[133:102], reads_generation[197:134],
   // writes_generation[261:198], zero pad[263:262]
   input  logic [263:0] req_tdata,
   // kind[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // verdict[2:0], failing_stage[8:3], zero pad[15:9]
   output logic [15:0]  rsp_tdata,
   output logic         rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_CHECK, ST_SCAN, ST_EVAL, ST_FINISH
   } state_type;

   state_type state_ff;

   logic [COUNT_W-1:0] stage_index_ff;
   logic [GEN_W-1:0]   cur_gen_ff;
   logic [GEN_W-1:0]   pend_gen_ff;
   logic [MASK_W-1:0]  reader_ff;
   logic [MASK_W-1:0]  writer_ff;
   logic [MASK_W-1:0]  publish_ff;
   verdict_type        err_ff;
   logic [COUNT_W-1:0] estage_ff;

   logic [COUNT_W-1:0] count_ff;
   logic [GEN_W-1:0]   init_gen_ff;
   logic [KIND_W-1:0]  kind_ff;
   logic [ID_W-1:0]    ident_ff;
   logic [MASK_W-1:0]  deps_ff;
   logic [GEN_W-1:0]   rd_gen_ff;
   logic [GEN_W-1:0]   wr_gen_ff;
   logic               last_ff;

   logic               rsp_valid_ff;
   verdict_type        rsp_verdict_ff;
   logic [COUNT_W-1:0] rsp_stage_ff;
   logic               rsp_last_ff;

   logic               req_accept;
   logic               item_last;
   logic               stage_out_of_range;
   logic [MASK_W-1:0]  earlier_mask;
   logic [MASK_W-1:0]  stage_bit;
   logic [IDX_W-1:0]   stage_addr;
   logic               scan_start;
   scan_status_type    scan_status;
   logic               scan_dup;
   logic [MASK_W-1:0]  scan_anc;
   logic               mem_rd_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   entry_type          mem_rd_data;
   logic               mem_wr_en;
   entry_type          mem_wr_data;
   verdict_type        eval_verdict;
   verdict_type        fin_verdict;
   logic [COUNT_W-1:0] fin_stage;
   logic               out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign item_last = (req_tdata[5:0] == '0) ||
                      (({1'b0, stage_index_ff} + (COUNT_W + 1)'(1)) >= {1'b0, req_tdata[5:0]});

   assign stage_out_of_range = (stage_index_ff >= COUNT_W'(MAX_STAGES));
   assign stage_addr         = stage_index_ff[IDX_W-1:0];
   // Shift amounts are below the mask width whenever these are used.
   assign stage_bit          = MASK_W'(1) << stage_index_ff;
   assign earlier_mask       = stage_bit - MASK_W'(1);

   assign scan_start = (state_ff == ST_CHECK) && (err_ff == VERDICT_OK) &&
                       !stage_out_of_range && (ident_ff != '0) &&
                       ((deps_ff & ~earlier_mask) == '0);

   // Ordering rules of each kind, applied once the scan is complete.
   always_comb begin
      eval_verdict = VERDICT_OK;
      if (scan_dup) begin
         eval_verdict = VERDICT_DUP;
      end else begin
         case (kind_ff) inside
            KIND_FORWARD, KIND_TRANSPOSE, KIND_EDGE_GRAD: begin
               if (pend_gen_ff != '0 || rd_gen_ff != cur_gen_ff || wr_gen_ff != '0 ||
                   (scan_anc & publish_ff) != publish_ff) begin
                  eval_verdict = VERDICT_STALE;
               end
            end
            KIND_UPDATE: begin
               if (pend_gen_ff != '0 || rd_gen_ff != cur_gen_ff ||
                   wr_gen_ff <= cur_gen_ff ||
                   (scan_anc & (reader_ff | publish_ff)) != (reader_ff | publish_ff)) begin
                  eval_verdict = VERDICT_STATE;
               end
            end
            KIND_PUBLISH: begin
               if (pend_gen_ff == '0 || rd_gen_ff != pend_gen_ff || wr_gen_ff != '0 ||
                   (scan_anc & writer_ff) != writer_ff) begin
                  eval_verdict = VERDICT_STATE;
               end
            end
            default: eval_verdict = VERDICT_KIND;
         endcase
      end
   end

   assign mem_wr_en            = (state_ff == ST_EVAL) && (eval_verdict == VERDICT_OK);
   assign mem_wr_data.identity  = ident_ff;
   assign mem_wr_data.ancestors = scan_anc;

   // A closing stage with a mutation still unpublished is an invalid state.
   always_comb begin
      fin_verdict = err_ff;
      fin_stage   = estage_ff;
      if (last_ff && err_ff == VERDICT_OK && pend_gen_ff != '0) begin
         fin_verdict = VERDICT_STATE;
         fin_stage   = stage_index_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         stage_index_ff <= '0;
         cur_gen_ff     <= '0;
         pend_gen_ff    <= '0;
         reader_ff      <= '0;
         writer_ff      <= '0;
         publish_ff     <= '0;
         err_ff         <= VERDICT_OK;
         estage_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  count_ff    <= req_tdata[5:0];
                  init_gen_ff <= req_tdata[69:6];
                  ident_ff    <= req_tdata[101:70];
                  deps_ff     <= req_tdata[133:102];
                  rd_gen_ff   <= req_tdata[197:134];
                  wr_gen_ff   <= req_tdata[261:198];
                  kind_ff     <= req_tuser;
                  last_ff     <= item_last;
                  state_ff    <= ST_PREP;
               end
            end
            ST_PREP: begin
               if (stage_index_ff == '0) begin
                  cur_gen_ff  <= init_gen_ff;
                  pend_gen_ff <= '0;
                  reader_ff   <= '0;
                  writer_ff   <= '0;
                  publish_ff  <= '0;
                  estage_ff   <= '0;
                  if (count_ff == '0 || count_ff > COUNT_W'(MAX_STAGES) ||
                      init_gen_ff == '0) begin
                     err_ff <= VERDICT_ARG;
                  end else begin
                     err_ff <= VERDICT_OK;
                  end
               end
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (err_ff != VERDICT_OK) begin
                  state_ff <= ST_FINISH;
               end else if (scan_start) begin
                  state_ff <= ST_SCAN;
               end else begin
                  err_ff    <= VERDICT_ARG;
                  estage_ff <= stage_index_ff;
                  state_ff  <= ST_FINISH;
               end
            end
            ST_SCAN: begin
               if (scan_status.done) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               if (eval_verdict != VERDICT_OK) begin
                  err_ff    <= eval_verdict;
                  estage_ff <= stage_index_ff;
               end else begin
                  case (kind_ff)
                     KIND_UPDATE: begin
                        pend_gen_ff <= wr_gen_ff;
                        writer_ff   <= stage_bit;
                     end
                     KIND_PUBLISH: begin
                        cur_gen_ff  <= pend_gen_ff;
                        pend_gen_ff <= '0;
                        reader_ff   <= '0;
                        publish_ff  <= stage_bit;
                     end
                     default: reader_ff <= reader_ff | stage_bit;
                  endcase
               end
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  err_ff         <= fin_verdict;
                  estage_ff      <= fin_stage;
                  rsp_verdict_ff <= fin_verdict;
                  rsp_stage_ff   <= fin_stage;
                  rsp_last_ff    <= last_ff;
                  stage_index_ff <= last_ff ? '0 : stage_index_ff + COUNT_W'(1);
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   eoc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .stage     (stage_addr),
      .identity  (ident_ff),
      .depends   (deps_ff),
      .status    (scan_status),
      .dup       (scan_dup),
      .ancestors (scan_anc),
      .rd_en     (mem_rd_en),
      .rd_addr   (mem_rd_addr),
      .rd_data   (mem_rd_data)
   );

   eoc_stage_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (stage_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_stage_ff, rsp_verdict_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // No new word may be taken while the scan still walks the memory.
   a_ready_not_scanning: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !scan_status.busy)
      else $error("request taken while the scan unit is busy");

   // The scan reports completion only to a controller that waits for it.
   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_status.done |-> (state_ff == ST_SCAN))
      else $error("scan completion outside the scan phase");

   // A clean verdict never names a failing stage.
   a_ok_stage_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2:0] == VERDICT_OK) |-> (rsp_tdata[8:3] == '0))
      else $error("ok verdict with a nonzero failing stage");

   // Entries are written only while no error is recorded for the sequence.
   a_write_clean: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (err_ff == VERDICT_OK))
      else $error("stage memory written after an error");
`endif

endmodule

/* rtl/eoc_stage_mem.sv */
// Stage memory: identity and ancestor mask of each stage of a sequence.
// One write port, one registered read port. Depends on eoc_pkg.
module eoc_stage_mem
   import eoc_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MAX_STAGES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/eoc_scan.sv */
// Scan unit: walks the entries of all earlier stages, one read a cycle,
// flags a repeated identity and gathers the ancestor mask. Depends on eoc_pkg.
module eoc_scan
   import eoc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [IDX_W-1:0]  stage,
   input  logic [ID_W-1:0]   identity,
   input  logic [MASK_W-1:0] depends,
   output scan_status_type   status,
   output logic              dup,
   output logic [MASK_W-1:0] ancestors,
   output logic              rd_en,
   output logic [IDX_W-1:0]  rd_addr,
   input  entry_type         rd_data
);

   logic              busy_ff;
   logic              done_ff;
   logic              rvalid_ff;
   logic [IDX_W-1:0]  issue_ff;
   logic [IDX_W-1:0]  rj_ff;
   logic [IDX_W-1:0]  limit_ff;
   logic [ID_W-1:0]   ident_ff;
   logic [MASK_W-1:0] deps_ff;
   logic              dup_ff;
   logic [MASK_W-1:0] anc_ff;

   assign rd_en   = busy_ff && (issue_ff < limit_ff);
   assign rd_addr = issue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         if (start) begin
            busy_ff   <= 1'b1;
            done_ff   <= 1'b0;
            rvalid_ff <= 1'b0;
            issue_ff  <= '0;
            limit_ff  <= stage;
            ident_ff  <= identity;
            deps_ff   <= depends;
            dup_ff    <= 1'b0;
            anc_ff    <= '0;
         end else if (busy_ff) begin
            if (rd_en) begin
               issue_ff <= issue_ff + IDX_W'(1);
            end
            rvalid_ff <= rd_en;
            rj_ff     <= issue_ff;
            // Read data of the previous cycle belongs to entry rj_ff.
            if (rvalid_ff) begin
               if (rd_data.identity == ident_ff) begin
                  dup_ff <= 1'b1;
               end
               if (deps_ff[rj_ff]) begin
                  anc_ff <= anc_ff | rd_data.ancestors | (MASK_W'(1) << rj_ff);
               end
            end
            if (!rd_en && !rvalid_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               done_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign dup         = dup_ff;
   assign ancestors   = anc_ff;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of effect_order_checker: stage words stream in, and every
// verdict word is compared with a predictor kept in step with the accepted stages.
// Depends on eoc_pkg and the effect_order_checker RTL.
module testbench;
   import eoc_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 500;
   // Kinds above KIND_PUBLISH are unassigned.
   localparam logic [KIND_W-1:0] KIND_MAX = '1;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [GEN_W-1:0]   init_gen;
      logic [KIND_W-1:0]  kind;
      logic [ID_W-1:0]    identity;
      logic [MASK_W-1:0]  deps;
      logic [GEN_W-1:0]   rd_gen;
      logic [GEN_W-1:0]   wr_gen;
      logic               drain_first;
   } stage_word_type;

   typedef struct packed {
      verdict_type  verdict;
      logic         closing;
      logic [5:0]   stage;
   } verdict_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [263:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  rsp_tdata;
   logic         rsp_tlast;

   effect_order_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   stage_word_type   stage_queue[$];
   verdict_word_type expected_verdicts[$];
   stage_word_type   offered_word;
   int               words_sent = 0;
   int               results_seen = 0;
   int               error_count = 0;
   int               quiet_cycles = 0;
   int               hold_left = 0;
   bit               hold_done = 1'b0;

   // Stimulus-side bookkeeping: position within the sequence being queued.
   int            queued_seq_pos = 0;
   bit            drain_next = 1'b0;

   // Checker state as the predictor sees it.
   logic [5:0]        seq_pos = '0;
   logic [ID_W-1:0]   id_mem [MAX_STAGES];
   logic [MASK_W-1:0] anc_mem [MAX_STAGES];
   logic [GEN_W-1:0]  cur_gen = '0;
   logic [GEN_W-1:0]  pend_gen = '0;
   logic [MASK_W-1:0] reader_mask = '0;
   logic [MASK_W-1:0] writer_mask = '0;
   logic [MASK_W-1:0] publisher_mask = '0;
   verdict_type       err_code = VERDICT_OK;
   logic [5:0]        err_stage = '0;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic add_word(input logic [COUNT_W-1:0] count, input logic [GEN_W-1:0] init,
                           input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] ident,
                           input logic [MASK_W-1:0] deps, input logic [GEN_W-1:0] rd,
                           input logic [GEN_W-1:0] wr);
      stage_word_type w;
      w.count = count;
      w.init_gen = init;
      w.kind = kind;
      w.identity = ident;
      w.deps = deps;
      w.rd_gen = rd;
      w.wr_gen = wr;
      w.drain_first = drain_next;
      drain_next = 1'b0;
      stage_queue.push_back(w);
      if (count == 0 || queued_seq_pos + 1 >= int'(count))
         queued_seq_pos = 0;
      else
         queued_seq_pos++;
   endtask

   // Advances the checker state by one accepted stage and queues its verdict word.
   function automatic void predict_stage(input stage_word_type w);
      logic              closing;
      verdict_type       v;
      logic [MASK_W-1:0] bit_i, earlier, anc, need;
      verdict_word_type  r;
      closing = (w.count == 0) || (int'(seq_pos) + 1 >= int'(w.count));
      if (seq_pos == 0) begin
         cur_gen = w.init_gen;
         pend_gen = '0;
         reader_mask = '0;
         writer_mask = '0;
         publisher_mask = '0;
         err_code = VERDICT_OK;
         err_stage = '0;
         if (w.count == 0 || int'(w.count) > MAX_STAGES || w.init_gen == 0)
            err_code = VERDICT_ARG;
      end
      if (err_code == VERDICT_OK) begin
         v = VERDICT_OK;
         anc = '0;
         if (int'(seq_pos) >= MAX_STAGES) begin
            v = VERDICT_ARG;
         end else begin
            bit_i = 32'd1 << seq_pos;
            earlier = bit_i - 32'd1;
            if (w.identity == 0 || (w.deps & ~earlier) != 0) begin
               v = VERDICT_ARG;
            end else begin
               for (int j = 0; j < int'(seq_pos); j++) begin
                  if (id_mem[j] == w.identity)
                     v = VERDICT_DUP;
                  if (w.deps[j])
                     anc |= anc_mem[j] | (32'd1 << j);
               end
            end
            if (v == VERDICT_OK) begin
               case (w.kind)
                  KIND_FORWARD, KIND_TRANSPOSE, KIND_EDGE_GRAD: begin
                     if (pend_gen != 0 || w.rd_gen != cur_gen || w.wr_gen != 0
                         || (anc & publisher_mask) != publisher_mask)
                        v = VERDICT_STALE;
                     else
                        reader_mask |= bit_i;
                  end
                  KIND_UPDATE: begin
                     need = reader_mask | publisher_mask;
                     if (pend_gen != 0 || w.rd_gen != cur_gen || w.wr_gen <= cur_gen
                         || (anc & need) != need) begin
                        v = VERDICT_STATE;
                     end else begin
                        pend_gen = w.wr_gen;
                        writer_mask = bit_i;
                     end
                  end
                  KIND_PUBLISH: begin
                     if (pend_gen == 0 || w.rd_gen != pend_gen || w.wr_gen != 0
                         || (anc & writer_mask) != writer_mask) begin
                        v = VERDICT_STATE;
                     end else begin
                        cur_gen = pend_gen;
                        pend_gen = '0;
                        reader_mask = '0;
                        publisher_mask = bit_i;
                     end
                  end
                  default: v = VERDICT_KIND;
               endcase
            end
         end
         if (v == VERDICT_OK) begin
            id_mem[seq_pos] = w.identity;
            anc_mem[seq_pos] = anc;
         end else begin
            err_code = v;
            err_stage = seq_pos;
         end
      end
      // A mutation still waiting for its publication spoils a clean sequence.
      if (closing && err_code == VERDICT_OK && pend_gen != 0) begin
         err_code = VERDICT_STATE;
         err_stage = seq_pos;
      end
      r.verdict = err_code;
      r.closing = closing;
      r.stage = err_stage;
      expected_verdicts.push_back(r);
      seq_pos = closing ? 6'd0 : seq_pos + 6'd1;
   endfunction

   // Sender: offers queued stage words with random gaps.
   always @(posedge clock) begin
      bit             offer;
      stage_word_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_stage(offered_word);
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            offer = stage_queue.size() != 0;
            if (offer && stage_queue[0].drain_first && expected_verdicts.size() != 0)
               offer = 1'b0;
            if (offer && !(words_sent >= 700 && words_sent < 1000)
                && $urandom_range(0, 99) < 12)
               offer = 1'b0;
            if (offer) begin
               nxt = stage_queue.pop_front();
               offered_word = nxt;
               req_tdata <= {2'b00, nxt.wr_gen, nxt.rd_gen, nxt.deps, nxt.identity,
                             nxt.init_gen, nxt.count};
               req_tuser <= nxt.kind;
            end
            req_tvalid <= offer;
         end
      end
   end

   // Receiver: checks each verdict word and applies back-pressure.
   always @(posedge clock) begin
      verdict_word_type exp_word;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               $error("unexpected response word: verdict %0d failing_stage %0d",
                      rsp_tdata[2:0], rsp_tdata[8:3]);
               error_count++;
            end else begin
               exp_word = expected_verdicts.pop_front();
               if (rsp_tdata[2:0] !== exp_word.verdict) begin
                  $error("verdict: expected %0d, got %0d", exp_word.verdict, rsp_tdata[2:0]);
                  error_count++;
               end
               if (rsp_tlast !== exp_word.closing) begin
                  $error("sequence_done: expected %0d, got %0d", exp_word.closing, rsp_tlast);
                  error_count++;
               end
               if (rsp_tdata[8:3] !== exp_word.stage) begin
                  $error("failing_stage: expected %0d, got %0d", exp_word.stage,
                         rsp_tdata[8:3]);
                  error_count++;
               end
            end
            results_seen++;
         end
         // One long stall lets the block fill up while the sender keeps offering.
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen == 300) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (results_seen >= 700 && results_seen < 1000)
                          || $urandom_range(0, 99) >= 12;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

   initial begin
      int                n, i, k, roll, fault, fault_at, drain_mark;
      bit                overrun, dup;
      logic [COUNT_W-1:0] cnt;
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   ident;
      logic [MASK_W-1:0] deps, required, bit_i, earlier;
      logic [GEN_W-1:0]  g, init, rd, wr, g_cur, g_pend;
      logic [MASK_W-1:0] g_rd_set, g_wr_set, g_pub_set;
      logic [ID_W-1:0]   ids [MAX_STAGES];

      g = (rand64() >> 1) | 64'd1;
      // Bad counts and a zero start generation fail at stage 0; the count may
      // change inside a sequence, which is how the fourth word here closes it.
      add_word(6'd0, rand64(), KIND_FORWARD, $urandom, '0, rand64(), '0);
      add_word(6'd63, g, KIND_FORWARD, 32'h7, '0, g, '0);
      add_word(6'd33, g, KIND_TRANSPOSE, 32'h8, 32'h1, g, '0);
      add_word(6'd2, g, KIND_FORWARD, 32'h9, '0, g, '0);
      add_word(6'd1, '0, KIND_FORWARD, 32'h5, '0, '0, '0);
      add_word(6'd1, '1, KIND_FORWARD, '1, '0, '1, '0);
      // Read, update, publication, then a read of the new generation.
      add_word(6'd4, g, KIND_TRANSPOSE, 32'h11, '0, g, '0);
      add_word(6'd4, g, KIND_UPDATE, 32'h12, 32'h1, g, g + 1);
      add_word(6'd4, g, KIND_PUBLISH, 32'h13, 32'h2, g + 1, '0);
      add_word(6'd4, g, KIND_EDGE_GRAD, 32'h14, 32'h4, g + 1, '0);
      // An update that is never published.
      add_word(6'd2, g, KIND_FORWARD, 32'h21, '0, g, '0);
      add_word(6'd2, g, KIND_UPDATE, 32'h22, 32'h1, g, '1);
      for (k = KIND_PUBLISH + 1; k <= KIND_MAX; k++)
         add_word(6'd1, g, 3'(k), 32'h30 + k, '0, g, '0);
      add_word(6'd1, g, KIND_FORWARD, '0, '0, g, '0);
      add_word(6'd2, g, KIND_FORWARD, 32'h40, '0, g, '0);
      add_word(6'd2, g, KIND_FORWARD, 32'h40, 32'h1, g, '0);
      add_word(6'd2, g, KIND_FORWARD, 32'h50, '0, g, '0);
      add_word(6'd2, g, KIND_EDGE_GRAD, 32'h51, '1, g, '0);
      add_word(6'd2, g, KIND_FORWARD, 32'h60, '0, g, '0);
      add_word(6'd2, g, KIND_TRANSPOSE, 32'h61, 32'h1, g + 5, '0);
      add_word(6'd2, g, KIND_UPDATE, 32'h70, '0, g, g + 2);
      add_word(6'd2, g, KIND_PUBLISH, 32'h71, '0, g + 2, '0);

      drain_mark = 400;
      while (stage_queue.size() < 1620) begin
         if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 3))
               add_word(6'($urandom_range(0, 63)), rand64(), 3'($urandom_range(0, KIND_MAX)),
                        $urandom, $urandom, rand64(), rand64());
            continue;
         end
         // Noise may leave a sequence open; close it before a clean one starts.
         if (queued_seq_pos != 0)
            add_word(6'd1, rand64(), KIND_FORWARD, $urandom, $urandom, rand64(), rand64());
         if (stage_queue.size() >= drain_mark) begin
            drain_next = 1'b1;
            drain_mark += 700;
         end
         roll = $urandom_range(0, 99);
         n = roll < 2 ? MAX_STAGES : roll < 12 ? $urandom_range(9, MAX_STAGES - 1)
                                                : $urandom_range(1, 8);
         overrun = (n == MAX_STAGES) && $urandom_range(0, 1);
         fault_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
         fault = $urandom_range(0, 8);
         if (fault == 8 && fault_at >= 0)
            fault_at = n - 1;
         init = rand64();
         if (init == 0)
            init = 64'd1;
         g_cur = init;
         g_pend = '0;
         g_rd_set = '0;
         g_wr_set = '0;
         g_pub_set = '0;
         for (i = 0; i < n; i++) begin
            bit_i = 32'd1 << i;
            earlier = bit_i - 32'd1;
            cnt = (overrun && i == n - 1) ? 6'd40 : 6'(n);
            if (g_pend != 0)
               kind = KIND_PUBLISH;
            else if (i < n - 1 && g_cur != '1 && $urandom_range(0, 2) == 0)
               kind = KIND_UPDATE;
            else
               kind = 3'($urandom_range(KIND_FORWARD, KIND_EDGE_GRAD));
            if (i == fault_at && fault == 8 && g_pend == 0 && g_cur != '1)
               kind = KIND_UPDATE;
            do begin
               ident = $urandom;
               dup = 1'b0;
               for (k = 0; k < i; k++)
                  if (ids[k] == ident)
                     dup = 1'b1;
            end while (ident == 0 || dup);
            case (kind)
               KIND_PUBLISH: required = g_wr_set;
               KIND_UPDATE:  required = g_rd_set | g_pub_set;
               default:      required = g_pub_set;
            endcase
            deps = required | ($urandom & earlier);
            rd = (kind == KIND_PUBLISH) ? g_pend : g_cur;
            wr = '0;
            if (kind == KIND_UPDATE) begin
               wr = ($urandom_range(0, 3) == 0) ? rand64() : g_cur + 1 + $urandom_range(0, 15);
               if (wr <= g_cur)
                  wr = g_cur + 1;
            end
            if (i == fault_at) begin
               case (fault)
                  0: ident = '0;
                  1: ident = (i > 0) ? ids[$urandom_range(0, i - 1)] : '0;
                  2: deps |= 32'd1 << $urandom_range(i, MASK_W - 1);
                  3: rd ^= 64'd1 << $urandom_range(0, GEN_W - 1);
                  4: wr = (kind == KIND_UPDATE) ? g_cur : rand64() | 64'd1;
                  5: kind = 3'($urandom_range(KIND_PUBLISH + 1, KIND_MAX));
                  6: deps = '0;
                  7: cnt = 6'($urandom_range(0, 63));
                  default: ;
               endcase
            end
            ids[i] = ident;
            add_word(cnt, init, kind, ident, deps, rd, wr);
            case (kind)
               KIND_FORWARD, KIND_TRANSPOSE, KIND_EDGE_GRAD: g_rd_set |= bit_i;
               KIND_UPDATE: begin
                  g_pend = wr;
                  g_wr_set = bit_i;
               end
               KIND_PUBLISH: begin
                  g_cur = g_pend;
                  g_pend = '0;
                  g_rd_set = '0;
                  g_pub_set = bit_i;
               end
               default: ;
            endcase
         end
         // The count grew on the last stage, so one more stage lands past the stores.
         if (overrun)
            add_word(6'd33, init, KIND_FORWARD, $urandom | 32'd1, '0, g_cur, '0);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (stage_queue.size() != 0 || req_tvalid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* effect_order_checker.f */
rtl/eoc_pkg.sv
rtl/eoc_stage_mem.sv
rtl/eoc_scan.sv
rtl/effect_order_checker.sv
dv/testbench.sv
